FILE: src/cfrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrd_pkg
// Shared types and constants of the capture file record deframer.
// ----------------------------------------------------------------------------
package cfrd_pkg;

  // magic words, read most significant byte first
  localparam logic [31:0] MAGIC_BIG    = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_LITTLE = 32'hd4c3b2a1;

  // header byte positions
  localparam logic [4:0] MAGIC_LAST_POS  = 5'd3;
  localparam logic [4:0] MAGIC_END_POS   = 5'd4;
  localparam logic [4:0] SNAP_LAST_POS   = 5'd19;
  localparam logic [4:0] GLOBAL_LAST_POS = 5'd23;
  localparam logic [4:0] SEC_LAST_POS    = 5'd3;
  localparam logic [4:0] USEC_LAST_POS   = 5'd7;
  localparam logic [4:0] INCL_LAST_POS   = 5'd11;
  localparam logic [4:0] RECORD_LAST_POS = 5'd15;

  // region codes seen on the result channel
  localparam logic [1:0] REGION_GLOBAL = 2'd0;
  localparam logic [1:0] REGION_RECORD = 2'd1;
  localparam logic [1:0] REGION_DATA   = 2'd2;
  localparam logic [1:0] REGION_HALT   = 2'd3;

  // fault codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

  typedef enum logic [3:0] {
    PH_GLOBAL = 4'b0001,
    PH_RECORD = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_HALT   = 4'b1000
  } cfrd_phase_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [1:0]  region;
    logic [31:0] region_offset;
    logic [31:0] packet_index;
    logic        header_done;
    logic        little_endian;
    logic [31:0] snap_length;
    logic [31:0] stamp_sec;
    logic [31:0] stamp_usec;
    logic [31:0] packet_length;
    logic        last_of_packet;
    logic [1:0]  error_code;
  } cfrd_result_t;

endpackage

FILE: src/cfrd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrd_if
// Valid/ready channels of the deframer: raw file bytes in, tagged bytes out.
// ----------------------------------------------------------------------------
interface cfrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

interface cfrd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_byte;
  logic [1:0]  region;
  logic [31:0] region_offset;
  logic [31:0] packet_index;
  logic        header_done;
  logic        little_endian;
  logic [31:0] snap_length;
  logic [31:0] stamp_sec;
  logic [31:0] stamp_usec;
  logic [31:0] packet_length;
  logic        last_of_packet;
  logic [1:0]  error_code;

  modport source (
    output valid, output echo_byte, output region, output region_offset,
    output packet_index, output header_done, output little_endian,
    output snap_length, output stamp_sec, output stamp_usec,
    output packet_length, output last_of_packet, output error_code,
    input ready
  );
  modport sink (
    input valid, input echo_byte, input region, input region_offset,
    input packet_index, input header_done, input little_endian,
    input snap_length, input stamp_sec, input stamp_usec,
    input packet_length, input last_of_packet, input error_code,
    output ready
  );
endinterface

FILE: src/cfrd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrd_parser
// Parse state of the capture file and the per-byte next-state logic.
// ----------------------------------------------------------------------------
module cfrd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            byte_in,
  input  logic                  sof_in,
  output cfrd_pkg::cfrd_result_t res
);
  import cfrd_pkg::*;

  cfrd_phase_t phase_r, phase_nxt, cur_phase;
  logic [4:0]  hcnt_r, hcnt_nxt, cur_hcnt;
  logic [31:0] asm_r, asm_nxt, cur_asm;
  logic        le_r, le_nxt, cur_le;
  logic [31:0] snap_r, snap_nxt, cur_snap;
  logic [31:0] sec_r, sec_nxt, cur_sec;
  logic [31:0] usec_r, usec_nxt, cur_usec;
  logic [31:0] len_r, len_nxt, cur_len;
  logic [31:0] dpos_r, dpos_nxt, cur_dpos;
  logic [31:0] pkt_r, pkt_nxt, cur_pkt;
  logic [1:0]  fault_r, fault_nxt, cur_fault;

  // shift a byte into the field being assembled, in file byte order
  function automatic logic [31:0] gather(input logic [31:0] word, input logic [7:0] b,
                                         input logic [4:0] pos, input logic little);
    logic first;
    first = (pos[1:0] == 2'd0);
    if (little) return (first ? 32'd0 : (word >> 8)) | {b, 24'd0};
    else        return (first ? 32'd0 : (word << 8)) | {24'd0, b};
  endfunction

  // start of file restarts from reset values with this byte
  always_comb begin
    cur_phase = sof_in ? PH_GLOBAL : phase_r;
    cur_hcnt  = sof_in ? 5'd0      : hcnt_r;
    cur_asm   = sof_in ? 32'd0     : asm_r;
    cur_le    = sof_in ? 1'b0      : le_r;
    cur_snap  = sof_in ? 32'd0     : snap_r;
    cur_sec   = sof_in ? 32'd0     : sec_r;
    cur_usec  = sof_in ? 32'd0     : usec_r;
    cur_len   = sof_in ? 32'd0     : len_r;
    cur_dpos  = sof_in ? 32'd0     : dpos_r;
    cur_pkt   = sof_in ? 32'd0     : pkt_r;
    cur_fault = sof_in ? ERR_NONE  : fault_r;
  end

  always_comb begin
    logic bad_magic;
    bad_magic = 1'b0;
    phase_nxt = cur_phase;
    hcnt_nxt  = cur_hcnt;
    asm_nxt   = cur_asm;
    le_nxt    = cur_le;
    snap_nxt  = cur_snap;
    sec_nxt   = cur_sec;
    usec_nxt  = cur_usec;
    len_nxt   = cur_len;
    dpos_nxt  = cur_dpos;
    pkt_nxt   = cur_pkt;
    fault_nxt = cur_fault;
    res.region         = REGION_HALT;
    res.region_offset  = 32'd0;
    res.header_done    = 1'b0;
    res.last_of_packet = 1'b0;

    unique case (cur_phase)
      PH_GLOBAL: begin
        res.region        = REGION_GLOBAL;
        res.region_offset = {27'd0, cur_hcnt};
        if (cur_hcnt < MAGIC_END_POS) begin
          asm_nxt = gather(cur_asm, byte_in, cur_hcnt, 1'b0);
          if (cur_hcnt == MAGIC_LAST_POS) begin
            priority if (asm_nxt == MAGIC_BIG) begin
              le_nxt = 1'b0;
            end else if (asm_nxt == MAGIC_LITTLE) begin
              le_nxt = 1'b1;
            end else begin
              bad_magic = 1'b1;
            end
          end
        end else begin
          asm_nxt = gather(cur_asm, byte_in, cur_hcnt, cur_le);
          if (cur_hcnt == SNAP_LAST_POS) snap_nxt = asm_nxt;
        end
        if (bad_magic) begin
          fault_nxt = ERR_BAD_MAGIC;
          phase_nxt = PH_HALT;
        end else if (cur_hcnt >= GLOBAL_LAST_POS) begin
          phase_nxt = PH_RECORD;
          hcnt_nxt  = 5'd0;
        end else begin
          hcnt_nxt = cur_hcnt + 5'd1;
        end
      end
      PH_RECORD: begin
        res.region        = REGION_RECORD;
        res.region_offset = {27'd0, cur_hcnt};
        asm_nxt = gather(cur_asm, byte_in, cur_hcnt, cur_le);
        if (cur_hcnt == SEC_LAST_POS)  sec_nxt  = asm_nxt;
        if (cur_hcnt == USEC_LAST_POS) usec_nxt = asm_nxt;
        if (cur_hcnt == INCL_LAST_POS) len_nxt  = asm_nxt;
        if (cur_hcnt >= RECORD_LAST_POS) begin
          res.header_done = 1'b1;
          hcnt_nxt = 5'd0;
          priority if (cur_len > cur_snap) begin
            fault_nxt = ERR_TOO_LONG;
            phase_nxt = PH_HALT;
          end else if (cur_len == 32'd0) begin
            res.last_of_packet = 1'b1;
            pkt_nxt = cur_pkt + 32'd1;
          end else begin
            phase_nxt = PH_DATA;
            dpos_nxt  = 32'd0;
          end
        end else begin
          hcnt_nxt = cur_hcnt + 5'd1;
        end
      end
      PH_DATA: begin
        res.region        = REGION_DATA;
        res.region_offset = cur_dpos;
        if (cur_len == 32'd0 || cur_dpos >= cur_len - 32'd1) begin
          res.last_of_packet = 1'b1;
          pkt_nxt   = cur_pkt + 32'd1;
          phase_nxt = PH_RECORD;
          hcnt_nxt  = 5'd0;
          dpos_nxt  = 32'd0;
        end else begin
          dpos_nxt = cur_dpos + 32'd1;
        end
      end
      default: begin
        res.region = REGION_HALT;
      end
    endcase

    res.echo_byte     = byte_in;
    res.packet_index  = cur_pkt;
    res.little_endian = le_nxt;
    res.snap_length   = snap_nxt;
    res.stamp_sec     = sec_nxt;
    res.stamp_usec    = usec_nxt;
    res.packet_length = len_nxt;
    res.error_code    = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GLOBAL;
      hcnt_r  <= 5'd0;
      asm_r   <= 32'd0;
      le_r    <= 1'b0;
      snap_r  <= 32'd0;
      sec_r   <= 32'd0;
      usec_r  <= 32'd0;
      len_r   <= 32'd0;
      dpos_r  <= 32'd0;
      pkt_r   <= 32'd0;
      fault_r <= ERR_NONE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      asm_r   <= asm_nxt;
      le_r    <= le_nxt;
      snap_r  <= snap_nxt;
      sec_r   <= sec_nxt;
      usec_r  <= usec_nxt;
      len_r   <= len_nxt;
      dpos_r  <= dpos_nxt;
      pkt_r   <= pkt_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

FILE: src/capture_file_record_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_file_record_deframer
// Byte-wide capture file parser: global header, record headers, packet data.
// ----------------------------------------------------------------------------
// The block takes a capture file one byte per request and returns one tagged
// request per byte, in order. Throughput is one byte per clock while the
// result channel does not stall; each byte passes the input register, then
// the result register. The parse state updates once per byte, which sets
// that rate. The magic word picks the file byte order; a bad magic word or
// an included length above the snapshot length halts the block (region 3)
// until a byte with start_of_file set, which restarts parsing at global
// header byte 0. Decoded header fields hold their values until overwritten.
module capture_file_record_deframer (
  input logic       clk,
  input logic       rst_n,
  cfrd_in_if.sink   in_ch,
  cfrd_out_if.source out_ch
);
  import cfrd_pkg::*;

  // input register
  logic       s0_vld_r;
  logic [7:0] s0_byte_r;
  logic       s0_sof_r;

  // result register
  logic         out_vld_r;
  cfrd_result_t res_r;
  cfrd_result_t step_res;

  logic out_adv;  // result register can load this cycle
  logic fire;     // input register hands its byte to the parser

  assign out_adv     = !out_vld_r || out_ch.ready;
  assign fire        = s0_vld_r && out_adv;
  assign in_ch.ready = !s0_vld_r || out_adv;

  // parse state and per-byte decode
  cfrd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .byte_in (s0_byte_r),
    .sof_in  (s0_sof_r),
    .res     (step_res)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) s0_vld_r <= in_ch.valid;
      if (out_adv)     out_vld_r <= s0_vld_r;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_byte_r <= in_ch.in_byte;
      s0_sof_r  <= in_ch.start_of_file;
    end
    if (fire) res_r <= step_res;
  end

  // drive the result channel
  assign out_ch.valid          = out_vld_r;
  assign out_ch.echo_byte      = res_r.echo_byte;
  assign out_ch.region         = res_r.region;
  assign out_ch.region_offset  = res_r.region_offset;
  assign out_ch.packet_index   = res_r.packet_index;
  assign out_ch.header_done    = res_r.header_done;
  assign out_ch.little_endian  = res_r.little_endian;
  assign out_ch.snap_length    = res_r.snap_length;
  assign out_ch.stamp_sec      = res_r.stamp_sec;
  assign out_ch.stamp_usec     = res_r.stamp_usec;
  assign out_ch.packet_length  = res_r.packet_length;
  assign out_ch.last_of_packet = res_r.last_of_packet;
  assign out_ch.error_code     = res_r.error_code;

endmodule

FILE: verif/capture_file_record_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_file_record_deframer_test
// Self-checking bench for the capture file deframer. Builds capture files
// (both byte orders, zero-length and oversize records, bad magic words,
// truncated files, stray bytes), streams them through the valid/ready input
// with random gaps and back-pressure, and compares every tagged byte on the
// result channel with a byte-accurate parser model kept in a scoreboard.
// ----------------------------------------------------------------------------
module capture_file_record_deframer_test;
  import cfrd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, fills the block
  localparam int QUIET_LIMIT     = 4000;  // cycles with no request moving on either side
  localparam int ITEMS_PER_PHASE = 420;
  localparam int REPORT_LIMIT    = 10;

  // --------------------------------------------------------------------------
  // parser model and result store
  // --------------------------------------------------------------------------
  class deframe_scoreboard;
    cfrd_phase_t  phase;
    logic [4:0]   hdr_count;
    logic [31:0]  word;
    logic         little;
    logic [31:0]  snap;
    logic [31:0]  sec;
    logic [31:0]  usec;
    logic [31:0]  rec_len;
    logic [31:0]  data_pos;
    logic [31:0]  pkt_count;
    logic [1:0]   fault;
    cfrd_result_t tagged_q[$];
    int           failures;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PH_GLOBAL;
      hdr_count = '0;
      word      = '0;
      little    = 1'b0;
      snap      = '0;
      sec       = '0;
      usec      = '0;
      rec_len   = '0;
      data_pos  = '0;
      pkt_count = '0;
      fault     = ERR_NONE;
    endfunction

    // shift one byte into the field being assembled, in file order
    function void gather(logic [7:0] b, logic le);
      logic first;
      first = (hdr_count[1:0] == 2'd0);
      if (le) begin
        word = (first ? 32'd0 : (word >> 8)) | {b, 24'd0};
      end else begin
        word = (first ? 32'd0 : (word << 8)) | {24'd0, b};
      end
    endfunction

    // one accepted input byte: advance the parser and store its tagged result
    function void note_request(logic [7:0] b, logic sof);
      cfrd_result_t r;
      if (sof) clear_state();
      r = '0;
      r.echo_byte    = b;
      r.packet_index = pkt_count;
      case (phase)
        PH_GLOBAL: begin
          r.region        = REGION_GLOBAL;
          r.region_offset = {27'd0, hdr_count};
          if (hdr_count < MAGIC_END_POS) begin
            gather(b, 1'b0);
            if (hdr_count == MAGIC_LAST_POS) begin
              if (word == MAGIC_BIG) begin
                little = 1'b0;
              end else if (word == MAGIC_LITTLE) begin
                little = 1'b1;
              end else begin
                fault = ERR_BAD_MAGIC;
                phase = PH_HALT;
              end
            end
          end else begin
            gather(b, little);
            if (hdr_count == SNAP_LAST_POS) snap = word;
          end
          if (phase == PH_GLOBAL) begin
            if (hdr_count >= GLOBAL_LAST_POS) begin
              phase     = PH_RECORD;
              hdr_count = '0;
            end else begin
              hdr_count = hdr_count + 5'd1;
            end
          end
        end
        PH_RECORD: begin
          r.region        = REGION_RECORD;
          r.region_offset = {27'd0, hdr_count};
          gather(b, little);
          if (hdr_count == SEC_LAST_POS) sec = word;
          else if (hdr_count == USEC_LAST_POS) usec = word;
          else if (hdr_count == INCL_LAST_POS) rec_len = word;
          if (hdr_count >= RECORD_LAST_POS) begin
            r.header_done = 1'b1;
            hdr_count     = '0;
            if (rec_len > snap) begin
              fault = ERR_TOO_LONG;
              phase = PH_HALT;
            end else if (rec_len == 32'd0) begin
              // empty packet ends on its own header
              r.last_of_packet = 1'b1;
              pkt_count        = pkt_count + 32'd1;
            end else begin
              phase    = PH_DATA;
              data_pos = '0;
            end
          end else begin
            hdr_count = hdr_count + 5'd1;
          end
        end
        PH_DATA: begin
          r.region        = REGION_DATA;
          r.region_offset = data_pos;
          if (rec_len == 32'd0 || data_pos >= rec_len - 32'd1) begin
            r.last_of_packet = 1'b1;
            pkt_count        = pkt_count + 32'd1;
            phase            = PH_RECORD;
            hdr_count        = '0;
            data_pos         = '0;
          end else begin
            data_pos = data_pos + 32'd1;
          end
        end
        default: begin
          r.region        = REGION_HALT;
          r.region_offset = '0;
        end
      endcase
      r.little_endian = little;
      r.snap_length   = snap;
      r.stamp_sec     = sec;
      r.stamp_usec    = usec;
      r.packet_length = rec_len;
      r.error_code    = fault;
      tagged_q.push_back(r);
    endfunction

    function string describe(cfrd_result_t r);
      return $sformatf({"byte %h region %0d offset %0d pkt %0d hd %b le %b snap %h ",
                        "sec %h usec %h len %h last %b err %0d"},
                       r.echo_byte, r.region, r.region_offset, r.packet_index,
                       r.header_done, r.little_endian, r.snap_length, r.stamp_sec,
                       r.stamp_usec, r.packet_length, r.last_of_packet, r.error_code);
    endfunction

    function void check_result(cfrd_result_t got);
      cfrd_result_t want;
      string        bad;
      if (tagged_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: %s", $time, describe(got));
        return;
      end
      want = tagged_q.pop_front();
      bad  = "";
      if (got.echo_byte      !== want.echo_byte)      bad = {bad, " echo_byte"};
      if (got.region         !== want.region)         bad = {bad, " region"};
      if (got.region_offset  !== want.region_offset)  bad = {bad, " region_offset"};
      if (got.packet_index   !== want.packet_index)   bad = {bad, " packet_index"};
      if (got.header_done    !== want.header_done)    bad = {bad, " header_done"};
      if (got.little_endian  !== want.little_endian)  bad = {bad, " little_endian"};
      if (got.snap_length    !== want.snap_length)    bad = {bad, " snap_length"};
      if (got.stamp_sec      !== want.stamp_sec)      bad = {bad, " stamp_sec"};
      if (got.stamp_usec     !== want.stamp_usec)     bad = {bad, " stamp_usec"};
      if (got.packet_length  !== want.packet_length)  bad = {bad, " packet_length"};
      if (got.last_of_packet !== want.last_of_packet) bad = {bad, " last_of_packet"};
      if (got.error_code     !== want.error_code)     bad = {bad, " error_code"};
      if (bad != "") begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
                   $time, bad, describe(want), describe(got));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  cfrd_in_if  in_ch ();
  cfrd_out_if out_ch ();

  capture_file_record_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframe_scoreboard sb = new();

  // idling knobs, changed per phase by the main sequence
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   hold_off_req   = 1'b0;
  int   items_sent     = 0;
  int   quiet_cycles   = 0;
  logic [7:0] file_q[$];
  cfrd_result_t observed;

  // --------------------------------------------------------------------------
  // monitor: note accepted bytes, check accepted results, watch for a hang
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      // input side first, so a byte is always predicted before it can come out
      if (in_ch.valid && in_ch.ready)
        sb.note_request(in_ch.in_byte, in_ch.start_of_file);
      if (out_ch.valid && out_ch.ready) begin
        observed.echo_byte      = out_ch.echo_byte;
        observed.region         = out_ch.region;
        observed.region_offset  = out_ch.region_offset;
        observed.packet_index   = out_ch.packet_index;
        observed.header_done    = out_ch.header_done;
        observed.little_endian  = out_ch.little_endian;
        observed.snap_length    = out_ch.snap_length;
        observed.stamp_sec      = out_ch.stamp_sec;
        observed.stamp_usec     = out_ch.stamp_usec;
        observed.packet_length  = out_ch.packet_length;
        observed.last_of_packet = out_ch.last_of_packet;
        observed.error_code     = out_ch.error_code;
        sb.check_result(observed);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a request moving", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // keep ready low while the sender keeps pushing, so the input backs up
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // input side: one byte per call, entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.start_of_file <= sof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // stream the built file; the start mark only on its first byte
  task automatic send_file(input logic mark_start);
    foreach (file_q[i]) send_byte(file_q[i], mark_start && (i == 0));
  endtask

  // append a 32-bit field in file byte order
  task automatic push_word(input logic [31:0] w, input logic le);
    if (le) begin
      file_q.push_back(w[7:0]);
      file_q.push_back(w[15:8]);
      file_q.push_back(w[23:16]);
      file_q.push_back(w[31:24]);
    end else begin
      file_q.push_back(w[31:24]);
      file_q.push_back(w[23:16]);
      file_q.push_back(w[15:8]);
      file_q.push_back(w[7:0]);
    end
  endtask

  // global header: magic always goes out most significant byte first
  task automatic push_global_header(input logic le, input logic [31:0] snap);
    push_word(le ? MAGIC_LITTLE : MAGIC_BIG, 1'b0);
    push_word($urandom, le);  // version
    push_word($urandom, le);  // time zone
    push_word($urandom, le);  // accuracy
    push_word(snap, le);
    push_word($urandom, le);  // link type
  endtask

  task automatic push_record(input logic le, input logic [31:0] sec, input logic [31:0] usec,
                             input logic [31:0] len, input int data_bytes);
    push_word(sec, le);
    push_word(usec, le);
    push_word(len, le);
    push_word($urandom, le);  // original length, not decoded
    repeat (data_bytes) file_q.push_back(8'($urandom_range(255)));
  endtask

  // included length: mostly fits, sometimes empty, at the limit or over it
  function automatic logic [31:0] pick_length(input logic [31:0] snap);
    int          k;
    logic [31:0] cap;
    k   = $urandom_range(99);
    cap = (snap > 32'd24) ? 32'd24 : snap;
    if (k < 10 || snap == 32'd0) return 32'd0;
    if (k < 16 && snap != 32'hffffffff) begin
      if (k < 13) return snap + 32'd1;
      return snap + 32'd1 + ($urandom % (32'hffffffff - snap));
    end
    if (k < 22) return cap;
    return $urandom_range(cap, 1);
  endfunction

  task automatic send_random_file();
    logic        le;
    logic [31:0] snap;
    logic [31:0] len;
    int          k;
    int          nrec;
    int          cut;
    file_q = {};
    le   = 1'($urandom_range(1));
    k    = $urandom_range(99);
    if (k < 10) snap = 32'd0;
    else if (k < 20) snap = 32'hffffffff;
    else if (k < 30) snap = $urandom;
    else snap = $urandom_range(40, 1);
    push_global_header(le, snap);
    nrec = $urandom_range(5, 1);
    for (int n = 0; n < nrec; n++) begin
      len = pick_length(snap);
      if (len > snap) begin
        // oversize record: the block halts, a few bytes land in the halted state
        push_record(le, $urandom, $urandom, len, $urandom_range(3, 1));
        break;
      end
      push_record(le, $urandom, $urandom, len, int'(len));
    end
    // damaged magic word
    if ($urandom_range(11) == 0) begin
      k = $urandom_range(3);
      file_q[k] = file_q[k] ^ 8'($urandom_range(255, 1));
    end
    // file cut short, the next start mark lands mid-stream
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(file_q.size() - 1, 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
    send_file(1'b1);
    // stray bytes between files, now and then with a start mark of their own
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(6, 1))
        send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  int idle_plan[4]  = '{0, 67, 0, 18};
  int stall_plan[4] = '{0, 0, 67, 18};

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = '0;
    in_ch.start_of_file = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no start mark after reset: big-endian file, snapshot length 8,
    // an empty packet, one exactly at the limit, then a one-byte packet
    file_q = {};
    push_word(MAGIC_BIG, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(32'hffffffff, 1'b0);
    push_word(32'd0, 1'b0);
    push_word(32'd8, 1'b0);
    push_word(32'hffffffff, 1'b0);
    push_record(1'b0, 32'hffffffff, 32'd0, 32'd0, 0);
    push_word(32'd0, 1'b0);
    push_word(32'hffffffff, 1'b0);
    push_word(32'd8, 1'b0);
    push_word(32'd0, 1'b0);
    file_q.push_back(8'h00);
    file_q.push_back(8'hff);
    file_q.push_back(8'h55);
    file_q.push_back(8'haa);
    file_q.push_back(8'h0f);
    file_q.push_back(8'hf0);
    file_q.push_back(8'h01);
    file_q.push_back(8'h80);
    push_record(1'b0, 32'h80000000, 32'h000f423f, 32'd1, 1);
    send_file(1'b0);

    // little-endian file, record one byte over snapshot length, then halted bytes
    file_q = {};
    push_global_header(1'b1, 32'd4);
    push_record(1'b1, 32'h12345678, 32'h0007a120, 32'd5, 0);
    file_q.push_back(8'hff);
    file_q.push_back(8'h00);
    send_file(1'b1);

    // bad magic word, one byte off, then a halted byte
    file_q = {8'ha1, 8'hb2, 8'hc3, 8'hd5, 8'h5a};
    send_file(1'b1);

    // random files under the four idling mixes
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      if (p == 0) hold_off_req = 1'b1;
      items_sent = 0;
      while (items_sent < ITEMS_PER_PHASE) send_random_file();
    end
    in_ch.valid <= 1'b0;

    // drain, then wait on for anything stray
    while (sb.tagged_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (sb.tagged_q.size() != 0) begin
      sb.failures++;
      $display("%0d expected results never arrived", sb.tagged_q.size());
    end
    if (sb.failures > REPORT_LIMIT)
      $display("%0d failures in total, only the first %0d shown", sb.failures, REPORT_LIMIT);
    if (sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
